// File: src/ble_enc_pkg.sv
// Shared types, constants and bit functions of the BLE CRC-24 and whitening encoder.
package ble_enc_pkg;

  localparam int unsigned CrcW = 24;
  localparam int unsigned ChanW = 6;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CrcW-1:0] CRC_POLY = 24'h00065B;
  localparam logic [7:0] WHT_TAPS = 8'h11;
  localparam logic [CrcW-1:0] CRC_INIT_RST = 24'h555555;
  localparam logic [ChanW-1:0] CHAN_RST = 6'd37;

  localparam logic [CfgIdxW-1:0] CFG_CRC_INIT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_CHANNEL = 1'b1;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_CRC0,
    PH_CRC1,
    PH_CRC2
  } phase_e;

  // Datapath selection from the sequencer.
  typedef struct packed {
    logic       tail;
    logic [1:0] sel;
  } dp_ctl_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } out_word_t;

  typedef struct packed {
    logic [7:0] wht;
    logic [7:0] data;
  } wht_res_t;

  function automatic logic [7:0] rev8(input logic [7:0] a);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = a[i];
    end
    return r;
  endfunction

  function automatic logic [7:0] wht_seed(input logic [ChanW-1:0] ch);
    logic [7:0] s;
    s = rev8({2'b00, ch}) | 8'h02;
    return s;
  endfunction

  // Eight bit-steps of the CRC, data LSB first.
  function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] c,
                                              input logic [7:0] d);
    logic [CrcW-1:0] r;
    logic            top;
    r = c;
    for (int i = 0; i < 8; i++) begin
      top = r[CrcW-1];
      r = {r[CrcW-2:0], 1'b0};
      if (top != d[i]) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic wht_res_t whiten(input logic [7:0] w, input logic [7:0] b);
    wht_res_t r;
    r.wht = w;
    r.data = b;
    for (int i = 0; i < 8; i++) begin
      if (r.wht[7]) begin
        r.wht = r.wht ^ WHT_TAPS;
        r.data[i] = ~r.data[i];
      end
      r.wht = {r.wht[6:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: src/ble_enc_in_if.sv
// Input channel: packet bytes with a last-byte flag.
interface ble_enc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: src/ble_enc_out_if.sv
// Output channel: encoded bytes for the radio.
interface ble_enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_out;

  modport source (output valid, output out_byte, output last_out, input ready);
  modport sink (input valid, input out_byte, input last_out, output ready);
endinterface

// File: src/ble_adv_packet_encoder_core.sv
// Top level of the BLE advertising packet CRC-24 and whitening encoder.
// Takes one packet byte per cycle while the output buffer has space, and
// writes its whitened, bit-reversed word into a two-word output buffer at
// the accepting edge, registered before it shows at the output. A byte
// flagged last is followed by the three CRC bytes, one per cycle while the
// buffer has space, and input is held off until the third goes in; the
// rate is set by the single word the encoder writes into the buffer each
// cycle. After the third CRC byte the CRC and whitening registers reload
// from crc_init and channel. A register write reloads both at once.
module ble_adv_packet_encoder_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ble_enc_in_if.sink                       in_if,
  ble_enc_out_if.source                    out_if,
  input  logic                             cfg_we_i,
  input  logic [ble_enc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ble_enc_pkg::CrcW-1:0]     cfg_data_i
);

  logic [ble_enc_pkg::CrcW-1:0]  crc_init_q, crc_init_d;
  logic [ble_enc_pkg::ChanW-1:0] chan_q, chan_d;
  logic [ble_enc_pkg::CrcW-1:0]  crc_q, crc_nxt;
  logic [7:0]                    wht_q, wht_nxt;
  ble_enc_pkg::phase_e           ph_q, ph_d;
  ble_enc_pkg::dp_ctl_t          ctl;
  ble_enc_pkg::out_word_t        word;
  logic                          last_tail;
  logic                          space;
  logic                          in_acc;
  logic                          push;
  logic [7:0]                    byte_enc;

  assign in_if.ready = (ph_q == ble_enc_pkg::PH_DATA) && space;
  assign in_acc      = in_if.valid && in_if.ready;

  always_comb begin
    crc_init_d = crc_init_q;
    chan_d     = chan_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ble_enc_pkg::CFG_CRC_INIT: crc_init_d = cfg_data_i;
        ble_enc_pkg::CFG_CHANNEL:  chan_d = cfg_data_i[ble_enc_pkg::ChanW-1:0];
        default: ;
      endcase
    end
  end

  // Next phase.
  always_comb begin
    ph_d = ph_q;
    unique case (ph_q)
      ble_enc_pkg::PH_DATA: if (in_acc && in_if.last_byte) ph_d = ble_enc_pkg::PH_CRC0;
      ble_enc_pkg::PH_CRC0: if (space) ph_d = ble_enc_pkg::PH_CRC1;
      ble_enc_pkg::PH_CRC1: if (space) ph_d = ble_enc_pkg::PH_CRC2;
      ble_enc_pkg::PH_CRC2: if (space) ph_d = ble_enc_pkg::PH_DATA;
      default:              ph_d = ble_enc_pkg::PH_DATA;
    endcase
  end

  // Phase outputs.
  always_comb begin
    push      = 1'b0;
    ctl.tail  = 1'b0;
    ctl.sel   = 2'd0;
    last_tail = 1'b0;
    unique case (ph_q)
      ble_enc_pkg::PH_DATA: push = in_acc;
      ble_enc_pkg::PH_CRC0: begin
        push     = space;
        ctl.tail = 1'b1;
        ctl.sel  = 2'd0;
      end
      ble_enc_pkg::PH_CRC1: begin
        push     = space;
        ctl.tail = 1'b1;
        ctl.sel  = 2'd1;
      end
      ble_enc_pkg::PH_CRC2: begin
        push      = space;
        ctl.tail  = 1'b1;
        ctl.sel   = 2'd2;
        last_tail = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

  assign word = '{out_byte: byte_enc, last_out: last_tail};

  ble_enc_datapath u_dp (
    .crc_i  (crc_q),
    .wht_i  (wht_q),
    .data_i (in_if.data_byte),
    .ctl_i  (ctl),
    .crc_o  (crc_nxt),
    .wht_o  (wht_nxt),
    .byte_o (byte_enc)
  );

  ble_enc_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (word),
    .space_o (space),
    .out_if  (out_if)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_init_q <= ble_enc_pkg::CRC_INIT_RST;
      chan_q     <= ble_enc_pkg::CHAN_RST;
      crc_q      <= ble_enc_pkg::CRC_INIT_RST;
      wht_q      <= ble_enc_pkg::wht_seed(ble_enc_pkg::CHAN_RST);
      ph_q       <= ble_enc_pkg::PH_DATA;
    end else begin
      crc_init_q <= crc_init_d;
      chan_q     <= chan_d;
      ph_q       <= ph_d;
      if (cfg_we_i) begin
        // Reload from the freshly written values.
        crc_q <= crc_init_d;
        wht_q <= ble_enc_pkg::wht_seed(chan_d);
      end else if (push && (ph_q == ble_enc_pkg::PH_CRC2)) begin
        crc_q <= crc_init_q;
        wht_q <= ble_enc_pkg::wht_seed(chan_q);
      end else if (push) begin
        crc_q <= crc_nxt;
        wht_q <= wht_nxt;
      end
    end
  end

endmodule

// File: src/ble_enc_datapath.sv
// One-byte CRC update and whitening for data bytes and CRC tail bytes.
module ble_enc_datapath (
  input  logic [ble_enc_pkg::CrcW-1:0] crc_i,
  input  logic [7:0]                   wht_i,
  input  logic [7:0]                   data_i,
  input  ble_enc_pkg::dp_ctl_t         ctl_i,
  output logic [ble_enc_pkg::CrcW-1:0] crc_o,
  output logic [7:0]                   wht_o,
  output logic [7:0]                   byte_o
);

  logic [7:0]            cb;
  logic [7:0]            wht_in;
  ble_enc_pkg::wht_res_t res;

  always_comb begin
    case (ctl_i.sel)
      2'd0:    cb = crc_i[23:16];
      2'd1:    cb = crc_i[15:8];
      default: cb = crc_i[7:0];
    endcase
  end

  // CRC holds still while its bytes go out.
  assign crc_o  = ctl_i.tail ? crc_i : ble_enc_pkg::crc_feed(crc_i, data_i);
  assign wht_in = ctl_i.tail ? ble_enc_pkg::rev8(cb) : data_i;
  assign res    = ble_enc_pkg::whiten(wht_i, wht_in);
  assign wht_o  = res.wht;
  assign byte_o = ble_enc_pkg::rev8(res.data);

endmodule

// File: src/ble_enc_obuf.sv
// Two-word output buffer between the encoder and the output channel.
module ble_enc_obuf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ble_enc_pkg::out_word_t word_i,
  output logic                   space_o,
  ble_enc_out_if.source          out_if
);

  ble_enc_pkg::out_word_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  ble_enc_pkg::out_word_t head;

  assign space_o = (cnt_q != 2'd2);
  assign pop     = out_if.valid && out_if.ready;
  assign head    = mem_q[rd_ptr_q];

  assign out_if.valid    = (cnt_q != 2'd0);
  assign out_if.out_byte = head.out_byte;
  assign out_if.last_out = head.last_out;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

endmodule

// File: src/ble_enc_checker.sv
// Port-level checks of the encoder, bound to the top level.
module ble_enc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("output word changed while stalled");

  // Every accepted byte leaves an output word valid in the next cycle.
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted byte produced no output word");

  // The CRC tail holds off input right after a last byte.
  a_tail_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input taken during CRC tail");

endmodule

bind ble_adv_packet_encoder_core ble_enc_checker u_ble_enc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_last_i   (in_if.last_byte),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_byte_i  (out_if.out_byte),
  .out_last_i  (out_if.last_out)
);

// File: dv/testbench.sv
// Self-checking bench for the BLE advertising CRC-24 and whitening encoder.
module testbench;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandBytes = 400;

  // Predicts the encoded words from accepted bytes and register writes.
  class adv_encoder_model;
    logic [ble_enc_pkg::CrcW-1:0]  crc_start;
    logic [ble_enc_pkg::ChanW-1:0] chan;
    logic [ble_enc_pkg::CrcW-1:0]  crc_acc;
    logic [7:0]                    lfsr;
    ble_enc_pkg::out_word_t        due_words[$];
    int                            n_mismatch;

    function new();
      crc_start = ble_enc_pkg::CRC_INIT_RST;
      chan = ble_enc_pkg::CHAN_RST;
      n_mismatch = 0;
      restart();
    endfunction

    function logic [7:0] flip8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
        r[i] = b[7-i];
      end
      return r;
    endfunction

    function void restart();
      crc_acc = crc_start;
      lfsr = flip8({2'b00, chan}) | 8'h02;
    endfunction

    function void crc_step(input logic [7:0] d);
      logic top;
      for (int i = 0; i < 8; i++) begin
        top = crc_acc[ble_enc_pkg::CrcW-1];
        crc_acc = {crc_acc[ble_enc_pkg::CrcW-2:0], 1'b0};
        if (top != d[i]) begin
          crc_acc = crc_acc ^ ble_enc_pkg::CRC_POLY;
        end
      end
    endfunction

    function logic [7:0] whiten_byte(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      for (int i = 0; i < 8; i++) begin
        if (lfsr[7]) begin
          lfsr = lfsr ^ ble_enc_pkg::WHT_TAPS;
          r[i] = ~r[i];
        end
        lfsr = {lfsr[6:0], 1'b0};
      end
      return r;
    endfunction

    function void take_byte(input logic [7:0] d, input logic l);
      ble_enc_pkg::out_word_t w;
      logic [7:0] cb;
      crc_step(d);
      w.out_byte = flip8(whiten_byte(d));
      w.last_out = 1'b0;
      due_words.push_back(w);
      if (l) begin
        // CRC goes out top byte first, then both registers reload
        for (int k = 0; k < 3; k++) begin
          cb = crc_acc[ble_enc_pkg::CrcW-1-8*k -: 8];
          w.out_byte = flip8(whiten_byte(flip8(cb)));
          w.last_out = (k == 2);
          due_words.push_back(w);
        end
        restart();
      end
    endfunction

    function void write_reg(input logic [ble_enc_pkg::CfgIdxW-1:0] idx,
                            input logic [ble_enc_pkg::CrcW-1:0] val);
      case (idx)
        ble_enc_pkg::CFG_CRC_INIT: crc_start = val;
        ble_enc_pkg::CFG_CHANNEL: chan = val[ble_enc_pkg::ChanW-1:0];
        default: ;
      endcase
      restart();
    endfunction

    function void match_word(input logic [7:0] ob, input logic lo);
      ble_enc_pkg::out_word_t w;
      if (due_words.size() == 0) begin
        $error("out_byte: no word due, got %h (last_out %b)", ob, lo);
        n_mismatch++;
        return;
      end
      w = due_words.pop_front();
      if (ob !== w.out_byte) begin
        $error("out_byte: expected %h, got %h", w.out_byte, ob);
        n_mismatch++;
      end
      if (lo !== w.last_out) begin
        $error("last_out: expected %b, got %b", w.last_out, lo);
        n_mismatch++;
      end
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we;
  logic [ble_enc_pkg::CfgIdxW-1:0]   cfg_idx;
  logic [ble_enc_pkg::CrcW-1:0]      cfg_data;
  bit                                calm;
  int unsigned                       cycles = 0;
  adv_encoder_model                  enc_model = new();

  ble_enc_in_if  in_ch ();
  ble_enc_out_if out_ch ();

  ble_adv_packet_encoder_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      enc_model.match_word(out_ch.out_byte, out_ch.last_out);
    end
  end

  // Receiver: stall a random number of cycles before taking each word.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Call just after a falling edge; returns just after a falling edge.
  task automatic send_byte(input logic [7:0] d, input logic l);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.data_byte = d;
    in_ch.last_byte = l;
    do @(posedge clk_i); while (!in_ch.ready);
    enc_model.take_byte(d, l);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (enc_model.due_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [ble_enc_pkg::CfgIdxW-1:0] idx,
                           input logic [ble_enc_pkg::CrcW-1:0] val);
    drain();
    repeat (4) @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(posedge clk_i);
    enc_model.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic send_packet(input int len, input bit noisy);
    logic l;
    for (int i = 0; i < len; i++) begin
      l = (i == len - 1);
      if (noisy) l = ($urandom_range(0, 3) == 0);
      send_byte(8'($urandom_range(0, 255)), l);
    end
  endtask

  initial begin
    int sent;
    int len;
    logic [ble_enc_pkg::ChanW-1:0] ch;
    rst_ni = 1'b0;
    calm = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = ble_enc_pkg::CFG_CRC_INIT;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings, then the register extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h55, 1'b1);
    write_reg(ble_enc_pkg::CFG_CRC_INIT, 24'h000000);
    write_reg(ble_enc_pkg::CFG_CHANNEL, 24'h000000);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    write_reg(ble_enc_pkg::CFG_CRC_INIT, 24'hFFFFFF);
    write_reg(ble_enc_pkg::CFG_CHANNEL, 24'h00003F);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7E, 1'b1);
    // Abandon a packet midway; upper data bits of a channel write are ignored
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h5A, 1'b0);
    write_reg(ble_enc_pkg::CFG_CHANNEL, {18'h2AD5B, 6'd39});
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    write_reg(ble_enc_pkg::CFG_CRC_INIT, 24'h555555);

    sent = 0;
    while (sent < RandBytes) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: write_reg(ble_enc_pkg::CFG_CRC_INIT,
                     ($urandom_range(0, 1) == 1) ? 24'hFFFFFF : 24'h000000);
        1: write_reg(ble_enc_pkg::CFG_CRC_INIT, 24'($urandom_range(0, 24'hFFFFFF)));
        default: ;
      endcase
      if ($urandom_range(0, 1) == 1) begin
        ch = 6'($urandom_range(0, 63));
        write_reg(ble_enc_pkg::CFG_CHANNEL, {18'($urandom_range(0, 18'h3FFFF)), ch});
      end
      repeat ($urandom_range(1, 4)) begin
        len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 39);
        send_packet(len, $urandom_range(0, 7) == 0);
        sent += len;
      end
      // Leave a packet unfinished; the next register write drops it
      if ($urandom_range(0, 5) == 0) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
        sent += len;
        write_reg(ble_enc_pkg::CFG_CRC_INIT, 24'($urandom_range(0, 24'hFFFFFF)));
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (enc_model.n_mismatch == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/ble_enc_pkg.sv
src/ble_enc_in_if.sv
src/ble_enc_out_if.sv
src/ble_enc_datapath.sv
src/ble_enc_obuf.sv
src/ble_adv_packet_encoder_core.sv
src/ble_enc_checker.sv
dv/testbench.sv
